// ----- hdl/acr_pkg.sv -----
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types and constants for the arc center pipeline: status codes,
// unit-vector scaling and the sideband words that ride beside the long units.
// ----------------------------------------------------------------------------
package acr_pkg;

	// unit vectors are Q1.30
	localparam int UNIT_BITS   = 30;
	localparam int MAG_W       = UNIT_BITS + 1;
	// square root of a 64-bit value, one result bit per stage
	localparam int SQRT_W      = 64;
	localparam int ROOT_W      = SQRT_W / 2;
	localparam int SQRT_STAGES = SQRT_W / 2;
	// restoring divider, one quotient bit per stage
	localparam int DIV_STAGES  = UNIT_BITS + 1;
	localparam int NUM_W       = 2 * UNIT_BITS + 3;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_COINCIDE     = 2'd1,
		ST_SHORT_RADIUS = 2'd2,
		ST_ZERO_AXIS    = 2'd3
	} status_t;

	// sideband beside the square root units
	typedef struct packed {
		logic                        valid;
		status_t                     status;
		logic                        minor;
		logic [2:0][31:0]            mid;
		logic [2:0][MAG_W-1:0]       mag_a;
		logic [2:0][MAG_W-1:0]       mag_d;
		logic [2:0]                  neg_a;
		logic [2:0]                  neg_d;
	} sq_side_t;

	// sideband beside the dividers
	typedef struct packed {
		logic                        valid;
		status_t                     status;
		logic                        minor;
		logic [2:0][31:0]            mid;
		logic [ROOT_W-1:0]           h;
		logic [2:0]                  neg_a;
		logic [2:0]                  neg_d;
	} div_side_t;

endpackage

// ----- hdl/arc_center_from_radius.sv -----
// ----------------------------------------------------------------------------
// arc_center_from_radius
// Center of a 3D arc from its endpoints, axis, radius and minor-arc flag,
// signed Q16.16 coordinates and an unsigned Q15.16 radius, with a status code for degenerate arcs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_ready   | start, end, axis, radius, minor_arc
//  out     | output    | out_valid / out_ready | center_x/y/z, status
//
//  one word accepted per cycle while the output is not stalled
//  the pipeline holds the 32-stage square root and the 31-stage dividers
//  the whole pipeline advances together; out_valid held without out_ready
//  freezes every stage and drops in_ready
//  arst_n clears all valid bits; no clearing pass
// ----------------------------------------------------------------------------
module arc_center_from_radius import acr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] start_z,
	input  logic [31:0] end_x,
	input  logic [31:0] end_y,
	input  logic [31:0] end_z,
	input  logic [31:0] axis_x,
	input  logic [31:0] axis_y,
	input  logic [31:0] axis_z,
	input  logic [30:0] radius,
	input  logic        minor_arc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] center_x,
	output logic [31:0] center_y,
	output logic [31:0] center_z,
	output logic [1:0]  status
);

	logic en;
	logic out_valid_q;

	// pipeline advances unless a result is waiting
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	logic [31:0] st_c [3];
	logic [31:0] en_c [3];
	logic [31:0] ax_c [3];
	logic [32:0] sum_c [3];

	always_comb begin
		st_c[0] = start_x; st_c[1] = start_y; st_c[2] = start_z;
		en_c[0] = end_x;   en_c[1] = end_y;   en_c[2] = end_z;
		ax_c[0] = axis_x;  ax_c[1] = axis_y;  ax_c[2] = axis_z;
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = {st_c[i][31], st_c[i]} + {en_c[i][31], en_c[i]};
		end
	end

	// valid bits of the front and back stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_s7, v_s8, v_s9, v_s10, v_s11;
	sq_side_t  sd;
	div_side_t dvo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			v_s10 <= 1'b0; v_s11 <= 1'b0; out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5;
			v_s7 <= dvo.valid;
			v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
			out_valid_q <= v_s11;
		end
	end

	// s1: chord, midpoint, degenerate flags
	logic signed [32:0] d_s1 [3];
	logic [31:0]        mid_s1 [3];
	logic [31:0]        ax_s1 [3];
	logic [30:0]        r_s1;
	logic               minor_s1, coin_s1, zax_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]   <= {en_c[i][31], en_c[i]} - {st_c[i][31], st_c[i]};
				mid_s1[i] <= sum_c[i][32:1];
				ax_s1[i]  <= ax_c[i];
			end
			r_s1     <= radius;
			minor_s1 <= minor_arc;
			coin_s1  <= (st_c[0] == en_c[0]) && (st_c[1] == en_c[1]) && (st_c[2] == en_c[2]);
			zax_s1   <= (ax_c[0] == '0) && (ax_c[1] == '0) && (ax_c[2] == '0);
		end
	end

	// s2: magnitudes and squares
	logic signed [65:0] dsq_c [3];
	logic [61:0]        r2_c;
	logic [32:0]        mag_d_s2 [3];
	logic [31:0]        mag_a_s2 [3];
	logic [2:0]         neg_d_s2, neg_a_s2;
	logic [64:0]        dsq_s2 [3];
	logic [63:0]        four_r2_s2;
	logic [31:0]        mid_s2 [3];
	logic               minor_s2, coin_s2, zax_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) dsq_c[i] = d_s1[i] * d_s1[i];
		r2_c = r_s1 * r_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_d_s2[i] <= d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
				mag_a_s2[i] <= ax_s1[i][31] ? (32'd0 - ax_s1[i]) : ax_s1[i];
				neg_d_s2[i] <= d_s1[i][32];
				neg_a_s2[i] <= ax_s1[i][31];
				dsq_s2[i]   <= dsq_c[i][64:0];
				mid_s2[i]   <= mid_s1[i];
			end
			four_r2_s2 <= {r2_c, 2'b00};
			minor_s2   <= minor_s1;
			coin_s2    <= coin_s1;
			zax_s2     <= zax_s1;
		end
	end

	// s3: leading bit of each vector, squared chord length
	logic [32:0] or_d_c, or_a_c;
	logic [5:0]  pos_d_c, pos_a_c;
	logic [5:0]  pos_d_s3, pos_a_s3;
	logic [32:0] mag_d_s3 [3];
	logic [31:0] mag_a_s3 [3];
	logic [2:0]  neg_d_s3, neg_a_s3;
	logic [66:0] d2_s3;
	logic [63:0] four_r2_s3;
	logic [31:0] mid_s3 [3];
	logic        minor_s3, coin_s3, zax_s3;

	always_comb begin
		or_d_c  = mag_d_s2[0] | mag_d_s2[1] | mag_d_s2[2];
		or_a_c  = {1'b0, mag_a_s2[0] | mag_a_s2[1] | mag_a_s2[2]};
		pos_d_c = '0;
		pos_a_c = '0;
		for (int b = 0; b < 33; b++) begin
			if (or_d_c[b]) pos_d_c = 6'(b);
			if (or_a_c[b]) pos_a_c = 6'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_d_s3 <= pos_d_c;
			pos_a_s3 <= pos_a_c;
			for (int i = 0; i < 3; i++) begin
				mag_d_s3[i] <= mag_d_s2[i];
				mag_a_s3[i] <= mag_a_s2[i];
				mid_s3[i]   <= mid_s2[i];
			end
			neg_d_s3   <= neg_d_s2;
			neg_a_s3   <= neg_a_s2;
			d2_s3      <= 67'(dsq_s2[0]) + 67'(dsq_s2[1]) + 67'(dsq_s2[2]);
			four_r2_s3 <= four_r2_s2;
			minor_s3   <= minor_s2;
			coin_s3    <= coin_s2;
			zax_s3     <= zax_s2;
		end
	end

	// s4: normalize magnitudes, status, offset radicand
	logic [63:0] shd_c [3];
	logic [63:0] sha_c [3];
	logic        short_c;
	status_t     status_c;
	sq_side_t    side_s4, side_s5, side_s6;
	logic [63:0] q_s4, q_s5, q_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_d_s3 >= 6'd30) shd_c[i] = 64'(mag_d_s3[i]) >> (pos_d_s3 - 6'd30);
			else                   shd_c[i] = 64'(mag_d_s3[i]) << (6'd30 - pos_d_s3);
			if (pos_a_s3 >= 6'd30) sha_c[i] = 64'(mag_a_s3[i]) >> (pos_a_s3 - 6'd30);
			else                   sha_c[i] = 64'(mag_a_s3[i]) << (6'd30 - pos_a_s3);
		end
		short_c = d2_s3 > {3'b000, four_r2_s3};
		if (coin_s3)      status_c = ST_COINCIDE;
		else if (short_c) status_c = ST_SHORT_RADIUS;
		else if (zax_s3)  status_c = ST_ZERO_AXIS;
		else              status_c = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.valid  <= v_s3;
			side_s4.status <= status_c;
			side_s4.minor  <= minor_s3;
			for (int i = 0; i < 3; i++) begin
				side_s4.mid[i]   <= mid_s3[i];
				side_s4.mag_a[i] <= sha_c[i][MAG_W-1:0];
				side_s4.mag_d[i] <= shd_c[i][MAG_W-1:0];
			end
			side_s4.neg_a <= neg_a_s3;
			side_s4.neg_d <= neg_d_s3;
			q_s4          <= four_r2_s3 - d2_s3[63:0];
		end
	end

	// s5: squares of the normalized components
	logic [61:0] nsq_a_s5 [3];
	logic [61:0] nsq_d_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nsq_a_s5[i] <= 62'(side_s4.mag_a[i]) * 62'(side_s4.mag_a[i]);
				nsq_d_s5[i] <= 62'(side_s4.mag_d[i]) * 62'(side_s4.mag_d[i]);
			end
			side_s5 <= side_s4;
			q_s5    <= q_s4;
		end
	end

	// s6: squared norms
	logic [63:0] n2a_s6, n2d_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n2a_s6  <= 64'(nsq_a_s5[0]) + 64'(nsq_a_s5[1]) + 64'(nsq_a_s5[2]);
			n2d_s6  <= 64'(nsq_d_s5[0]) + 64'(nsq_d_s5[1]) + 64'(nsq_d_s5[2]);
			side_s6 <= side_s5;
			q_s6    <= q_s5;
		end
	end

	// square roots: offset length and both norms
	logic [ROOT_W-1:0] h_w, na_w, nd_w;
	sq_side_t          sq_in;

	always_comb begin
		sq_in       = side_s6;
		sq_in.valid = v_s6;
	end

	acr_sqrt u_sq_h (.clk(clk), .en(en), .x(q_s6),   .root(h_w));
	acr_sqrt u_sq_a (.clk(clk), .en(en), .x(n2a_s6), .root(na_w));
	acr_sqrt u_sq_d (.clk(clk), .en(en), .x(n2d_s6), .root(nd_w));

	acr_delay #(.W($bits(sq_side_t)), .D(SQRT_STAGES)) u_dl_sq (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sq_in), .dout(sd)
	);

	// dividers: rounded unit components
	logic [NUM_W-1:0] num_a_c [3];
	logic [NUM_W-1:0] num_d_c [3];
	logic [MAG_W-1:0] qa_w [3];
	logic [MAG_W-1:0] qd_w [3];
	div_side_t        dv_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_a_c[i] = {2'b00, sd.mag_a[i], {UNIT_BITS{1'b0}}} + NUM_W'(na_w >> 1);
			num_d_c[i] = {2'b00, sd.mag_d[i], {UNIT_BITS{1'b0}}} + NUM_W'(nd_w >> 1);
		end
		dv_in.valid  = sd.valid;
		dv_in.status = sd.status;
		dv_in.minor  = sd.minor;
		dv_in.mid    = sd.mid;
		dv_in.h      = h_w;
		dv_in.neg_a  = sd.neg_a;
		dv_in.neg_d  = sd.neg_d;
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		acr_div u_div_a (.clk(clk), .en(en), .num(num_a_c[g]), .den(na_w), .quo(qa_w[g]));
		acr_div u_div_d (.clk(clk), .en(en), .num(num_d_c[g]), .den(nd_w), .quo(qd_w[g]));
	end

	acr_delay #(.W($bits(div_side_t)), .D(DIV_STAGES)) u_dl_div (
		.clk(clk), .arst_n(arst_n), .en(en), .din(dv_in), .dout(dvo)
	);

	// s7: signed unit vectors and cross product terms
	logic signed [31:0] ua_c [3];
	logic signed [31:0] ud_c [3];
	logic signed [63:0] pr_c [6];
	logic signed [63:0] pr_s7 [6];
	div_side_t          side_s7, side_s8, side_s9, side_s10, side_s11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ua_c[i] = dvo.neg_a[i] ? -$signed({1'b0, qa_w[i]}) : $signed({1'b0, qa_w[i]});
			ud_c[i] = dvo.neg_d[i] ? -$signed({1'b0, qd_w[i]}) : $signed({1'b0, qd_w[i]});
		end
		pr_c[0] = ua_c[1] * ud_c[2];
		pr_c[1] = ua_c[2] * ud_c[1];
		pr_c[2] = ua_c[2] * ud_c[0];
		pr_c[3] = ua_c[0] * ud_c[2];
		pr_c[4] = ua_c[0] * ud_c[1];
		pr_c[5] = ua_c[1] * ud_c[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) pr_s7[k] <= pr_c[k];
			side_s7 <= dvo;
		end
	end

	// s8: cross product in Q2.60
	logic signed [64:0] p_s8 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s8[i] <= 65'(pr_s7[2*i]) - 65'(pr_s7[2*i+1]);
			end
			side_s8 <= side_s7;
		end
	end

	// s9: round to Q2.30, offset direction
	logic [64:0] pm_c [3];
	logic [31:0] p30_s9 [3];
	logic [2:0]  neg_s9;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pm_c[i] = (p_s8[i][64] ? 65'(-p_s8[i]) : 65'(p_s8[i]))
				+ (65'd1 << (UNIT_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p30_s9[i] <= pm_c[i][2*UNIT_BITS+1:UNIT_BITS];
				neg_s9[i] <= p_s8[i][64] ^ !side_s8.minor;
			end
			side_s9 <= side_s8;
		end
	end

	// s10: scale by offset length
	logic [63:0] hp_c [3];
	logic [63:0] hp_s10 [3];
	logic [2:0]  neg_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) hp_c[i] = side_s9.h * p30_s9[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) hp_s10[i] <= hp_c[i];
			neg_s10  <= neg_s9;
			side_s10 <= side_s9;
		end
	end

	// s11: signed offset
	logic [63:0]        hr_c [3];
	logic signed [33:0] off_s11 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) hr_c[i] = hp_s10[i] + (64'd1 << UNIT_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				off_s11[i] <= neg_s10[i] ? -$signed({1'b0, hr_c[i][63:UNIT_BITS+1]})
				                         :  $signed({1'b0, hr_c[i][63:UNIT_BITS+1]});
			end
			side_s11 <= side_s10;
		end
	end

	// output register: add to midpoint and saturate; a degenerate status passes the midpoint
	logic signed [33:0] cs_c [3];
	logic [31:0]        cen_c [3];
	logic [31:0]        center_q [3];
	status_t            status_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cs_c[i] = 34'($signed(side_s11.mid[i])) + off_s11[i];
			if (side_s11.status != ST_OK)        cen_c[i] = side_s11.mid[i];
			else if (cs_c[i] > 34'sd2147483647)  cen_c[i] = 32'h7fff_ffff;
			else if (cs_c[i] < -34'sd2147483648) cen_c[i] = 32'h8000_0000;
			else                                 cen_c[i] = cs_c[i][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) center_q[i] <= cen_c[i];
			status_q <= side_s11.status;
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = center_q[0];
	assign center_y  = center_q[1];
	assign center_z  = center_q[2];
	assign status    = status_q;

endmodule

// ----- hdl/acr_delay.sv -----
// ----------------------------------------------------------------------------
// acr_delay
// Enabled shift line that keeps a sideband word aligned with a pipelined unit.
// ----------------------------------------------------------------------------
module acr_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_s [D];

	// shift one place per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < D; k++) line_s[k] <= '0;
		end else if (en) begin
			line_s[0] <= din;
			for (int k = 1; k < D; k++) line_s[k] <= line_s[k-1];
		end
	end

	assign dout = line_s[D-1];

endmodule

// ----- hdl/acr_sqrt.sv -----
// ----------------------------------------------------------------------------
// acr_sqrt
// Pipelined integer square root, floor(sqrt(x)), one result bit per stage.
// ----------------------------------------------------------------------------
module acr_sqrt import acr_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQRT_W-1:0] x,
	output logic [ROOT_W-1:0] root
);

	logic [SQRT_W-1:0] x_s  [SQRT_STAGES];
	logic [SQRT_W-1:0] r_s  [SQRT_STAGES];
	logic [SQRT_W-1:0] nx_c [SQRT_STAGES];
	logic [SQRT_W-1:0] nr_c [SQRT_STAGES];

	// one trial subtract per stage
	always_comb begin
		logic [SQRT_W-1:0] xi;
		logic [SQRT_W-1:0] ri;
		logic [SQRT_W-1:0] b;
		logic [SQRT_W-1:0] t;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			if (k == 0) begin
				xi = x;
				ri = '0;
			end else begin
				xi = x_s[k-1];
				ri = r_s[k-1];
			end
			b = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
			t = ri + b;
			if (xi >= t) begin
				nx_c[k] = xi - t;
				nr_c[k] = (ri >> 1) + b;
			end else begin
				nx_c[k] = xi;
				nr_c[k] = ri >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STAGES; k++) begin
				x_s[k] <= nx_c[k];
				r_s[k] <= nr_c[k];
			end
		end
	end

	assign root = r_s[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ----- hdl/acr_div.sv -----
// ----------------------------------------------------------------------------
// acr_div
// Pipelined restoring divider, one quotient bit per stage, quotient below 2^31.
// ----------------------------------------------------------------------------
module acr_div import acr_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output logic [MAG_W-1:0]  quo
);

	logic [NUM_W-1:0]  n_s  [DIV_STAGES];
	logic [ROOT_W-1:0] d_s  [DIV_STAGES];
	logic [MAG_W-1:0]  q_s  [DIV_STAGES];
	logic [NUM_W-1:0]  nn_c [DIV_STAGES];
	logic [ROOT_W-1:0] nd_c [DIV_STAGES];
	logic [MAG_W-1:0]  nq_c [DIV_STAGES];

	// compare and subtract the shifted divisor
	always_comb begin
		logic [NUM_W-1:0]  ni;
		logic [ROOT_W-1:0] di;
		logic [MAG_W-1:0]  qi;
		logic [NUM_W-1:0]  dv;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				ni = num;
				di = den;
				qi = '0;
			end else begin
				ni = n_s[k-1];
				di = d_s[k-1];
				qi = q_s[k-1];
			end
			dv = NUM_W'(di) << (DIV_STAGES - 1 - k);
			nd_c[k] = di;
			if (ni >= dv) begin
				nn_c[k] = ni - dv;
				nq_c[k] = qi | (MAG_W'(1) << (DIV_STAGES - 1 - k));
			end else begin
				nn_c[k] = ni;
				nq_c[k] = qi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				n_s[k] <= nn_c[k];
				d_s[k] <= nd_c[k];
				q_s[k] <= nq_c[k];
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule

// ----- hdl/acr_checker.sv -----
// ----------------------------------------------------------------------------
// acr_checker
// Port-level checks for the arc center pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module acr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] center_x,
	input logic [31:0] center_y,
	input logic [31:0] center_z,
	input logic [1:0]  status
);

	// input side frees up exactly when the output word can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track the output stall");

	// no word shows while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(center_x) && $stable(center_y)
			&& $stable(center_z) && $stable(status))
		else $error("stalled result changed");

	// nothing enters while the output is stalled
	a_no_entry_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("word accepted during an output stall");

endmodule

bind arc_center_from_radius acr_checker u_acr_checker (.*);
